@@ hw/rtl/dkh_pkg.sv @@
// Shared types, request codes and nucleotide decoding for the k-mer histogram.
// No dependencies; used by dkh_count_store and dna_kmer_histogram.
package dkh_pkg;

  // Widths of the result fields and of the request index field.
  localparam int unsigned OUT_COUNT_W = 20;
  localparam int unsigned OUT_INDEX_W = 10;

  // Input request modes.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_PUSH  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Nucleotide codes and the marker for a symbol that is not a nucleotide.
  localparam logic [2:0] NT_A   = 3'd0;
  localparam logic [2:0] NT_T   = 3'd1;
  localparam logic [2:0] NT_G   = 3'd2;
  localparam logic [2:0] NT_C   = 3'd3;
  localparam logic [2:0] NT_BAD = 3'd4;

  // Operation that a request performs on the count memory.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Control part of a request from the window logic to the count store.
  typedef struct packed {
    logic vld;
    op_t  op;
  } req_ctl_t;

  // Map an ASCII character (either case) to its 2-bit nucleotide code, or to NT_BAD otherwise.
  function automatic logic [2:0] nt_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      8'h61, 8'h41: code = NT_A;
      8'h74, 8'h54: code = NT_T;
      8'h67, 8'h47: code = NT_G;
      8'h63, 8'h43: code = NT_C;
      default:      code = NT_BAD;
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/dkh_count_store.sv @@
// Count memory with read-modify-write stage, forwarding, clearing pass and
// output register. Depends on dkh_pkg.
module dkh_count_store #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COUNT_BITS  = 20,
  parameter int unsigned ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dkh_pkg::req_ctl_t                req,
  input  logic [ADDR_W-1:0]                req_addr,
  input  logic [dkh_pkg::OUT_INDEX_W-1:0]  req_kidx,
  output logic                             req_ready,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dkh_pkg::OUT_COUNT_W-1:0]  out_count,
  output logic [dkh_pkg::OUT_INDEX_W-1:0]  out_kmer_index,
  output logic                             out_kmer_valid
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [ADDR_W-1:0]     ADDR_END = ADDR_W'(TABLE_DEPTH - 1);

  logic [COUNT_BITS-1:0] mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] mem_q_r;

  dkh_pkg::op_t                    s1_op_r;
  logic                            s1_vld_r;
  logic [ADDR_W-1:0]               s1_addr_r;
  logic [dkh_pkg::OUT_INDEX_W-1:0] s1_kidx_r;

  logic                  fwd_vld_r;
  logic [ADDR_W-1:0]     fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic              clr_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic                            out_vld_r;
  logic [dkh_pkg::OUT_COUNT_W-1:0] out_count_r;
  logic [dkh_pkg::OUT_INDEX_W-1:0] out_kidx_r;
  logic                            out_kvld_r;

  logic                  adv;
  logic                  take;
  logic                  do_inc;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;

  // Handshake between the request side, the update stage and the output register.
  assign adv       = s1_vld_r && (!out_vld_r || !out_stall);
  assign req_ready = (!s1_vld_r || adv) && !clr_r;
  assign take      = req.vld && req_ready;
  assign do_inc    = adv && (s1_op_r == dkh_pkg::OP_COUNT);

  // Current count, taking a write that landed after the read was issued.
  assign cur = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : mem_q_r;
  assign inc = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);

  // Count memory: one write port shared by the clearing pass and updates.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (do_inc) begin
      mem[s1_addr_r] <= inc;
    end
    if (take) begin
      mem_q_r <= mem[req_addr];
    end
  end

  // Update stage holding the request whose read data is in mem_q_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (take) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
    if (take) begin
      s1_op_r   <= req.op;
      s1_addr_r <= req_addr;
      s1_kidx_r <= req_kidx;
    end
  end

  // Last update written, for a read issued in the same cycle as that write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (clr_r || (take && req.op == dkh_pkg::OP_CLEAR)) begin
      fwd_vld_r <= 1'b0;
    end else if (do_inc) begin
      fwd_vld_r <= 1'b1;
    end
    if (do_inc) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= inc;
    end
  end

  // Clearing pass after reset and after every start request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (take && req.op == dkh_pkg::OP_CLEAR) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_r     <= (clr_cnt_r != ADDR_END);
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
    if (adv) begin
      case (s1_op_r)
        dkh_pkg::OP_COUNT: begin
          out_count_r <= dkh_pkg::OUT_COUNT_W'(inc);
          out_kidx_r  <= s1_kidx_r;
          out_kvld_r  <= 1'b1;
        end
        dkh_pkg::OP_READ: begin
          out_count_r <= dkh_pkg::OUT_COUNT_W'(cur);
          out_kidx_r  <= s1_kidx_r;
          out_kvld_r  <= 1'b1;
        end
        default: begin
          out_count_r <= '0;
          out_kidx_r  <= s1_kidx_r;
          out_kvld_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid      = out_vld_r;
  assign out_count      = out_count_r;
  assign out_kmer_index = out_kidx_r;
  assign out_kmer_valid = out_kvld_r;

  // The clearing pass runs through every entry once started.
  a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r && (clr_cnt_r != ADDR_END) |=> clr_r)
    else $error("clearing pass stopped early");

  // An update always records a nonzero count for forwarding, unless a start
  // request taken in the same cycle drops it.
  a_fwd_after_inc: assert property (@(posedge clk) disable iff (!rst_n)
    do_inc && !(take && req.op == dkh_pkg::OP_CLEAR) |=>
      fwd_vld_r && (fwd_data_r != '0))
    else $error("update not captured for forwarding");

  // A result without a counted or read entry carries a zero count.
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_kvld_r |-> out_count_r == '0)
    else $error("invalid result with nonzero count");

  // No request is taken while the memory is being cleared.
  a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !take && !do_inc)
    else $error("memory access during clearing pass");

endmodule

@@ hw/rtl/dna_kmer_histogram.sv @@
// Top level of the DNA k-mer histogram: symbol decoding, k-mer window and
// configuration. Depends on dkh_pkg and dkh_count_store.
//
// Counts overlapping k-mers of a nucleotide stream (a/t/g/c, either case,
// coded 0..3) in a memory of TABLE_DEPTH saturating counters; the window of the
// last k codes, oldest most significant, is the entry index. A push request
// gives the updated count when a full window exists, a read request returns one
// stored count, and a start request empties the window and clears all counts;
// any other character empties the window. Push and read requests are taken one
// per cycle unless the result output stalls or a clearing pass runs. Each result
// is held in the count memory's read register with the update stage, then in the
// output register. After reset and after each start request the block clears
// the memory one entry per cycle through its single write port, and takes no
// request until that pass ends. TABLE_DEPTH must be a power of two. word_len may
// be written only while the block is idle; cfg_ready is always high.
module dna_kmer_histogram #(
  parameter int unsigned MAX_WORD    = 5,
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_symbol,
  input  logic [9:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_count,
  output logic [9:0]  out_kmer_index,
  output logic        out_kmer_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_word_len
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned WIN_W  = 2 * MAX_WORD;
  localparam int unsigned FILL_W = $clog2(MAX_WORD + 1);

  logic [2:0]        word_len_r;
  logic [WIN_W-1:0]  win_r;
  logic [WIN_W-1:0]  win_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  dkh_pkg::req_ctl_t               req;
  logic [ADDR_W-1:0]               req_addr;
  logic [dkh_pkg::OUT_INDEX_W-1:0] req_kidx;
  logic                            req_ready;
  logic                            take;

  logic [2:0]       code;
  logic [3:0]       k;
  logic [WIN_W-1:0] win_sh;
  logic [WIN_W-1:0] win_key;
  logic             in_range;

  assign in_stall  = !req_ready;
  assign take      = in_valid && req_ready;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_len_r <= 3'd2;
    end else if (cfg_valid) begin
      word_len_r <= cfg_word_len;
    end
  end

  // Effective word length, clamped to 1..MAX_WORD.
  always_comb begin
    if (word_len_r == 3'd0) begin
      k = 4'd1;
    end else if ({1'b0, word_len_r} > 4'(MAX_WORD)) begin
      k = 4'(MAX_WORD);
    end else begin
      k = {1'b0, word_len_r};
    end
  end

  // Shifted window and the key formed by its newest k codes.
  assign code   = dkh_pkg::nt_code(in_symbol);
  assign win_sh = WIN_W'({win_r, code[1:0]});
  always_comb begin
    win_key = '0;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (4'(i) < k) begin
        win_key[2*i +: 2] = win_sh[2*i +: 2];
      end
    end
  end

  assign fill_nxt = (fill_r < FILL_W'(MAX_WORD)) ? fill_r + FILL_W'(1) : fill_r;
  assign in_range = {7'b0, in_read_index} < 17'(TABLE_DEPTH);

  // Build the request to the count store from the decoded input.
  always_comb begin
    req.vld  = in_valid;
    req.op   = dkh_pkg::OP_NONE;
    req_addr = '0;
    req_kidx = '0;
    win_nxt  = win_r;
    case (in_mode)
      dkh_pkg::MODE_START: begin
        req.op  = dkh_pkg::OP_CLEAR;
        win_nxt = '0;
      end
      dkh_pkg::MODE_PUSH: begin
        if (code == dkh_pkg::NT_BAD) begin
          win_nxt = '0;
        end else begin
          win_nxt = win_sh;
          if (4'(fill_nxt) >= k) begin
            req.op   = dkh_pkg::OP_COUNT;
            req_addr = ADDR_W'(win_key);
            req_kidx = dkh_pkg::OUT_INDEX_W'(ADDR_W'(win_key));
          end
        end
      end
      dkh_pkg::MODE_READ: begin
        req_kidx = in_read_index;
        if (in_range) begin
          req.op   = dkh_pkg::OP_READ;
          req_addr = ADDR_W'(in_read_index);
        end
      end
      default: begin
        req.op = dkh_pkg::OP_NONE;
      end
    endcase
  end

  // Window and fill state, updated when a request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
    end else if (take) begin
      win_r <= win_nxt;
      if (in_mode == dkh_pkg::MODE_START) begin
        fill_r <= '0;
      end else if (in_mode == dkh_pkg::MODE_PUSH) begin
        fill_r <= (code == dkh_pkg::NT_BAD) ? '0 : fill_nxt;
      end
    end
  end

  dkh_count_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS),
    .ADDR_W      (ADDR_W)
  ) u_store (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .req_addr       (req_addr),
    .req_kidx       (req_kidx),
    .req_ready      (req_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_count      (out_count),
    .out_kmer_index (out_kmer_index),
    .out_kmer_valid (out_kmer_valid)
  );

  // The fill count never exceeds the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fill_r} <= (FILL_W + 1)'(MAX_WORD))
    else $error("window fill out of range");

  // A start request leaves the window empty.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_mode == dkh_pkg::MODE_START |=> fill_r == '0 && win_r == '0)
    else $error("window not emptied by start request");

  // A rejected character leaves the window empty.
  a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_mode == dkh_pkg::MODE_PUSH && code == dkh_pkg::NT_BAD |=> fill_r == '0)
    else $error("window not emptied by non-nucleotide");

endmodule

@@ dv/tb_dna_kmer_histogram.sv @@
// Self-checking testbench for dna_kmer_histogram: a directed table, then random
// phases over all word_len settings, checked against a behavioral histogram.
// Depends on dkh_pkg and the dna_kmer_histogram RTL.
module tb_dna_kmer_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WORD    = 5;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned N_DIRECTED  = 24;
  localparam int unsigned N_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS = 165;
  localparam int unsigned QUIET_PHASE = 6;

  // Mode code that the block leaves unused.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Nucleotide letters in both cases, picked by byte position.
  localparam logic [63:0] BASE_LETTERS = "atgcATGC";

  typedef struct packed {
    logic [19:0] count;
    logic [9:0]  kmer_index;
    logic        kmer_valid;
  } kmer_reply_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  symbol;
    logic [9:0]  read_index;
    logic        has_result;
    kmer_reply_t result;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [7:0]  in_symbol;
  logic [9:0]  in_read_index;
  logic        out_valid;
  logic        out_stall;
  logic [19:0] out_count;
  logic [9:0]  out_kmer_index;
  logic        out_kmer_valid;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_word_len;

  // Behavioral copy of the block's state and its word_len register.
  logic [2:0]  k_setting;
  logic [9:0]  win_codes;
  logic [2:0]  win_fill;
  logic [19:0] hist [TABLE_DEPTH];
  logic [9:0]  last_index;

  // Replies still owed by the block, oldest first.
  kmer_reply_t due_replies[$];
  kmer_reply_t due;
  kmer_reply_t fresh;

  // Typed-in result of the directed row being offered, if it has one.
  logic        row_has_result;
  kmer_reply_t row_result;

  logic        quiet;
  int unsigned requests_taken;
  int unsigned replies_checked;
  int unsigned kmers_seen;
  int unsigned errors;

  // Directed rows; they all run at the reset word_len of 2.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{dkh_pkg::MODE_READ,  8'h00, 10'd0,   1'b1, '{20'd0, 10'd0,   1'b1}},
    '{dkh_pkg::MODE_READ,  8'hFF, 10'h3FF, 1'b1, '{20'd0, 10'h3FF, 1'b1}},
    '{dkh_pkg::MODE_PUSH,  "A",   10'h000, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_PUSH,  "c",   10'h3FF, 1'b1, '{20'd1, 10'd3,   1'b1}},
    '{dkh_pkg::MODE_PUSH,  "G",   10'h000, 1'b0, '0},
    '{dkh_pkg::MODE_PUSH,  "t",   10'h155, 1'b0, '0},
    '{dkh_pkg::MODE_PUSH,  "x",   10'h000, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_PUSH,  "T",   10'h000, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_PUSH,  "C",   10'h2AA, 1'b0, '0},
    '{dkh_pkg::MODE_PUSH,  8'hFF, 10'h000, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_PUSH,  8'h00, 10'h000, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{MODE_SPARE,          "A",   10'h155, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_PUSH,  "a",   10'h000, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_PUSH,  "a",   10'h000, 1'b0, '0},
    '{dkh_pkg::MODE_PUSH,  "A",   10'h000, 1'b0, '0},
    '{dkh_pkg::MODE_READ,  8'h00, 10'h000, 1'b0, '0},
    '{dkh_pkg::MODE_READ,  8'h55, 10'd14,  1'b0, '0},
    '{dkh_pkg::MODE_READ,  8'h00, 10'h2AA, 1'b0, '0},
    '{dkh_pkg::MODE_START, 8'hAA, 10'h3FF, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_READ,  8'h00, 10'd14,  1'b1, '{20'd0, 10'd14,  1'b1}},
    '{dkh_pkg::MODE_PUSH,  "g",   10'h000, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_PUSH,  "G",   10'h000, 1'b1, '{20'd1, 10'd10,  1'b1}},
    '{dkh_pkg::MODE_PUSH,  "N",   10'h000, 1'b1, '{20'd0, 10'd0,   1'b0}},
    '{dkh_pkg::MODE_READ,  8'h00, 10'd10,  1'b1, '{20'd1, 10'd10,  1'b1}}
  };

  // Settings walked by the random phases, extremes and out-of-range values included.
  logic [2:0] phase_word_len [N_PHASES] = '{
    3'd1, 3'd5, 3'd0, 3'd7, 3'd3, 3'd4, 3'd6, 3'd2, 3'd5, 3'd1
  };

  dna_kmer_histogram i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_symbol      (in_symbol),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_count      (out_count),
    .out_kmer_index (out_kmer_index),
    .out_kmer_valid (out_kmer_valid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_word_len   (cfg_word_len)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Map a character to its nucleotide code, or to the bad-symbol marker.
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    case (ch)
      "a", "A": return dkh_pkg::NT_A;
      "t", "T": return dkh_pkg::NT_T;
      "g", "G": return dkh_pkg::NT_G;
      "c", "C": return dkh_pkg::NT_C;
      default:  return dkh_pkg::NT_BAD;
    endcase
  endfunction

  // Apply one request to the behavioral histogram and work out its reply.
  task automatic tally_request(input logic [1:0] mode, input logic [7:0] symbol,
                               input logic [9:0] read_index, output kmer_reply_t reply);
    logic [2:0]  code;
    int unsigned k;
    logic [9:0]  idx_mask;
    logic [9:0]  idx;
    reply = '0;
    case (mode)
      dkh_pkg::MODE_START: begin
        for (int i = 0; i < TABLE_DEPTH; i++) hist[i] = '0;
        win_codes = '0;
        win_fill  = '0;
      end
      dkh_pkg::MODE_PUSH: begin
        code = base_code(symbol);
        if (code == dkh_pkg::NT_BAD) begin
          win_codes = '0;
          win_fill  = '0;
        end else begin
          // Zero acts as one and anything above the window size as the window size.
          k = (k_setting == 0) ? 1 : ((k_setting > MAX_WORD) ? MAX_WORD : k_setting);
          win_codes = {win_codes[7:0], code[1:0]};
          if (win_fill < MAX_WORD) win_fill = win_fill + 1'b1;
          if (win_fill >= k) begin
            // The newest k codes form the index; ten bits already wrap at the depth.
            idx_mask = 10'((32'd1 << (2 * k)) - 1);
            idx = win_codes & idx_mask;
            if (hist[idx] != '1) hist[idx] = hist[idx] + 1'b1;
            reply.count      = hist[idx];
            reply.kmer_index = idx;
            reply.kmer_valid = 1'b1;
            last_index       = idx;
          end
        end
      end
      dkh_pkg::MODE_READ: begin
        reply.kmer_index = read_index;
        if (int'(read_index) < TABLE_DEPTH) begin
          reply.count      = hist[read_index];
          reply.kmer_valid = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Random request: mostly nucleotides, with reads, noise, spare modes and rare starts.
  function automatic stim_row_t random_row();
    stim_row_t   row;
    int unsigned pick;
    row            = '0;
    row.symbol     = 8'($urandom);
    row.read_index = 10'($urandom);
    pick = $urandom_range(999);
    if (pick < 3) begin
      row.mode = dkh_pkg::MODE_START;
    end else if (pick < 13) begin
      row.mode = MODE_SPARE;
    end else if (pick < 130) begin
      row.mode = dkh_pkg::MODE_READ;
      if ($urandom_range(1) == 1) row.read_index = last_index;
    end else if (pick < 180) begin
      row.mode = dkh_pkg::MODE_PUSH;
    end else begin
      row.mode   = dkh_pkg::MODE_PUSH;
      row.symbol = BASE_LETTERS[8 * $urandom_range(7) +: 8];
    end
    return row;
  endfunction

  // Offer one request at the falling edge and hold it until the block takes it.
  task automatic send_request(input stim_row_t row);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= row.mode;
    in_symbol      <= row.symbol;
    in_read_index  <= row.read_index;
    row_has_result = row.has_result;
    row_result     = row.result;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Write word_len once every reply is in and the block takes requests again.
  task automatic write_word_len(input logic [2:0] value);
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_word_len <= value;
    do @(posedge clk); while (!cfg_ready);
    k_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result-side stall, off during the quiet phase.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 15);
  end

  // Check each reply against the oldest owed one, then log any request taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          $error("reply with no request pending: count %0d, kmer_index %0d",
                 out_count, out_kmer_index);
          errors++;
        end else begin
          due = due_replies.pop_front();
          if (out_count !== due.count) begin
            $error("count: expected %0d, actual %0d", due.count, out_count);
            errors++;
          end
          if (out_kmer_index !== due.kmer_index) begin
            $error("kmer_index: expected %0d, actual %0d", due.kmer_index, out_kmer_index);
            errors++;
          end
          if (out_kmer_valid !== due.kmer_valid) begin
            $error("kmer_valid: expected %0d, actual %0d", due.kmer_valid, out_kmer_valid);
            errors++;
          end
          replies_checked++;
          if (out_kmer_valid === 1'b1) kmers_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        tally_request(in_mode, in_symbol, in_read_index, fresh);
        if (row_has_result) fresh = row_result;
        due_replies.push_back(fresh);
        requests_taken++;
      end
    end
  end

  // Reset, directed table, random phases, then drain and report.
  initial begin : p_stimulus
    int unsigned drain_cycles;
    in_valid       = 1'b0;
    in_mode        = dkh_pkg::MODE_START;
    in_symbol      = '0;
    in_read_index  = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_word_len   = '0;
    rst_n          = 1'b0;
    quiet          = 1'b0;
    row_has_result = 1'b0;
    row_result     = '0;
    k_setting      = 3'd2;
    win_codes      = '0;
    win_fill       = '0;
    last_index     = '0;
    errors          = 0;
    requests_taken  = 0;
    replies_checked = 0;
    kmers_seen      = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) hist[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_request(directed_rows[i]);
    row_has_result = 1'b0;

    // Some phases start a new sequence, the others carry the window over.
    for (int p = 0; p < N_PHASES; p++) begin
      write_word_len(phase_word_len[p]);
      quiet = (p == QUIET_PHASE);
      if (p % 3 == 0) send_request('{dkh_pkg::MODE_START, 8'h00, 10'h000, 1'b0, '0});
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_row());
      quiet = 1'b0;
    end
    in_valid <= 1'b0;

    drain_cycles = 0;
    while (due_replies.size() != 0 && drain_cycles < 5000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (8) @(negedge clk);
    if (due_replies.size() != 0) begin
      $error("%0d replies never arrived", due_replies.size());
      errors++;
    end

    $display("Run took %0d requests over %0d word_len settings; %0d replies checked,",
             requests_taken, N_PHASES + 1, replies_checked);
    $display("%0d of them counted or read k-mers; %0d mismatches.", kmers_seen, errors);
    if (errors == 0) begin
      $display("[dna_kmer_histogram] OK");
    end else begin
      $display("[dna_kmer_histogram] ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : p_watchdog
    #4_000_000;
    $display("[dna_kmer_histogram] ERROR");
    $finish;
  end

endmodule
